// ===== design/lru_key_value_cache_core_assert.svh =====
// Assertion macros shared by the cache modules.
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LRUKV_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LRUKV_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lrukv_pkg.sv =====
// Package with the word types and constants of the key-value cache.
`timescale 1ns / 1ps

package lrukv_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Value returned by a get that finds nothing.
	localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

	// Value returned by every put.
	localparam logic signed [DATA_W-1:0] PUT_VALUE = 32'sd0;

	typedef enum logic [0:0] {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	// Request word.
	typedef struct packed {
		cmd_t                     command;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} req_t;

	// Result word.
	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;

endpackage

// ===== design/lrukv_store.sv =====
// Entry store: associative lookup, recency ranks, insertion and eviction.
`timescale 1ns / 1ps
`include "lru_key_value_cache_core_assert.svh"

module lrukv_store
	import lrukv_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  req_t             req,
	input  logic [CAP_W-1:0] capacity,
	output rsp_t             rsp
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CMP_W  = ((RANK_W > CAP_W) ? RANK_W : CAP_W) + 1;

	logic [DATA_W-1:0]  key_q   [ENTRIES];
	logic [DATA_W-1:0]  value_q [ENTRIES];
	logic [RANK_W-1:0]  rank_q  [ENTRIES];
	logic [RANK_W-1:0]  rank_d  [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] valid_d;
	logic [ENTRIES-1:0] write_en;

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] free_oh;
	logic [ENTRIES-1:0] lru_oh;
	logic [ENTRIES-1:0] slot_oh;
	logic               hit;
	logic [RANK_W-1:0]  hit_rank;
	logic [DATA_W-1:0]  hit_value;
	logic [CMP_W-1:0]   cap_eff;

	// Capacity zero acts as one; anything above the store size saturates.
	always_comb begin
		if (capacity == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = CMP_W'(capacity);
		end
	end

	// Compare the key against every valid entry; stored keys are unique.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_q[i] && (key_q[i] == req.key);
			lru_oh[i] = valid_q[i] && (rank_q[i] == RANK_W'(ENTRIES - 1));
		end
	end

	assign hit = |match;

	// Rank and value of the matching entry, selected by the one-hot match.
	always_comb begin
		hit_rank  = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_rank  = hit_rank | (match[i] ? rank_q[i] : '0);
			hit_value = hit_value | (match[i] ? value_q[i] : '0);
		end
	end

	// Lowest free slot; when the store is full, the least recent entry is reused.
	assign free_oh = ~valid_q & (valid_q + ENTRIES'(1));
	assign slot_oh = (&valid_q) ? lru_oh : free_oh;

	// Next valid bits and ranks for the item in flight.
	always_comb begin
		logic [CMP_W-1:0] aged;
		valid_d  = valid_q;
		write_en = '0;
		aged     = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
		end
		if (req_valid) begin
			if (hit) begin
				// Move the hit entry to the front; newer entries age by one.
				for (int i = 0; i < ENTRIES; i++) begin
					if (match[i]) begin
						rank_d[i] = '0;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_d[i] = rank_q[i] + RANK_W'(1);
					end
				end
				if (req.command == CMD_PUT) begin
					write_en = match;
				end
			end else if (req.command == CMD_PUT) begin
				// Insert as most recent, age the rest and drop those past capacity.
				write_en = slot_oh;
				for (int i = 0; i < ENTRIES; i++) begin
					aged = CMP_W'(rank_q[i]) + CMP_W'(1);
					if (slot_oh[i]) begin
						valid_d[i] = 1'b1;
						rank_d[i]  = '0;
					end else if (valid_q[i]) begin
						if (aged >= cap_eff) begin
							valid_d[i] = 1'b0;
							rank_d[i]  = '0;
						end else begin
							rank_d[i] = aged[RANK_W-1:0];
						end
					end
				end
			end
		end
	end

	// Control state: valid bits and ranks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	// Payload: keys and values, written only by puts.
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (write_en[i]) begin
				key_q[i]   <= req.key;
				value_q[i] <= req.value;
			end
		end
	end

	// Result word for the item in flight.
	always_comb begin
		rsp.hit = hit;
		if (req.command == CMD_PUT) begin
			rsp.read_value = PUT_VALUE;
		end else if (hit) begin
			rsp.read_value = hit_value;
		end else begin
			rsp.read_value = MISS_VALUE;
		end
	end

	`LRUKV_ASSERT_SAME(a_match_unique, req_valid, $onehot0(match), "Key matches several entries.")
	`LRUKV_ASSERT_NEXT(a_get_keeps_valid, req_valid && (req.command == CMD_GET), valid_q == $past(valid_q), "A get changed the valid bits.")
	`LRUKV_ASSERT_NEXT(a_insert_within_cap, req_valid && !hit && (req.command == CMD_PUT), ($countones(valid_q) <= $past(cap_eff)) && (valid_q != '0), "Insertion left the store above capacity or empty.")

endmodule

// ===== design/lru_key_value_cache_core.sv =====
// Top level of the fully associative key-value cache with LRU replacement.
`timescale 1ns / 1ps
`include "lru_key_value_cache_core_assert.svh"

// Channel    Handshake                Word
// request    start / busy             req_t: command, key, value
// result     done (strobe, no stall)  rsp_t: hit, read_value
// cfg        cfg_valid / cfg_ready    capacity (5 bits)
//
// One request word is taken in every cycle; busy stays low.
// An accepted request is held in the input register; the store looks it up and
// updates its entries as the result register captures the result, shown with done.
// Lookup, rank update and eviction all settle between the input and result registers.
// Reset clears all entries and sets the capacity to 16; no clearing pass is needed.

module lru_key_value_cache_core
	import lrukv_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             request,
	output logic             done,
	output rsp_t             result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	logic             valid_s1;
	req_t             req_s1;
	rsp_t             rsp;
	rsp_t             result_q;
	logic             done_q;
	logic [CAP_W-1:0] capacity_q;

	// The store takes a word every cycle and the register is always writable.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
	end

	lrukv_store #(
		.ENTRIES(ENTRIES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(valid_s1),
		.req      (req_s1),
		.capacity (capacity_q),
		.rsp      (rsp)
	);

	// Result register and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= rsp;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`LRUKV_ASSERT_NEXT(a_done_follows, valid_s1, done, "Accepted word produced no result.")
	`LRUKV_ASSERT_NEXT(a_put_zero, valid_s1 && (req_s1.command == CMD_PUT), result.read_value == PUT_VALUE, "Put result is not zero.")
	`LRUKV_ASSERT_NEXT(a_miss_value, valid_s1 && (req_s1.command == CMD_GET) && !rsp.hit, !result.hit && (result.read_value == MISS_VALUE), "Get miss result is wrong.")

endmodule

// ===== bench/lru_key_value_cache_core_tb.sv =====
// Self-checking testbench for the LRU key-value cache core.
`timescale 1ns / 1ps

module lru_key_value_cache_core_tb;
	import lrukv_pkg::*;

	localparam int ENTRIES = 16;

	// Tracks the expected cache contents and the results still owed by the block.
	class cache_scoreboard;
		logic [DATA_W-1:0] stored_key [ENTRIES];
		logic [DATA_W-1:0] stored_val [ENTRIES];
		bit                in_use     [ENTRIES];
		int                age        [ENTRIES];
		int                capacity;
		rsp_t              owed_q[$];
		int                errors;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				in_use[i] = 0;
				age[i] = 0;
			end
			capacity = CAP_RESET;
			errors = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			capacity = c;
		endfunction

		// Zero acts as one, and anything above the store size saturates.
		function int usable_capacity();
			if (capacity == 0) return 1;
			if (capacity > ENTRIES) return ENTRIES;
			return capacity;
		endfunction

		// Moves an entry to the front; newer entries age by one.
		function void make_newest(int idx);
			int r;
			r = age[idx];
			for (int i = 0; i < ENTRIES; i++)
				if (in_use[i] && age[i] < r) age[i]++;
			age[idx] = 0;
		endfunction

		// Inserts a new key, reusing the oldest slot when full, then trims to capacity.
		function void insert_key(logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
			int  slot;
			int  oldest;
			bit  found;
			int  cap;
			slot = 0;
			oldest = 0;
			found = 0;
			for (int i = 0; i < ENTRIES; i++)
				if (!found && !in_use[i]) begin
					slot = i;
					found = 1;
				end
			if (!found) begin
				for (int i = 0; i < ENTRIES; i++)
					if (age[i] >= oldest) begin
						oldest = age[i];
						slot = i;
					end
				in_use[slot] = 0;
			end
			for (int i = 0; i < ENTRIES; i++)
				if (in_use[i]) age[i]++;
			stored_key[slot] = k;
			stored_val[slot] = v;
			in_use[slot] = 1;
			age[slot] = 0;
			cap = usable_capacity();
			for (int i = 0; i < ENTRIES; i++)
				if (in_use[i] && age[i] >= cap) begin
					in_use[i] = 0;
					age[i] = 0;
				end
		endfunction

		// Applies one accepted request word and queues the result it owes.
		function void note(req_t w);
			rsp_t e;
			int   idx;
			bit   present;
			idx = 0;
			present = 0;
			for (int i = 0; i < ENTRIES; i++)
				if (!present && in_use[i] && stored_key[i] == w.key) begin
					idx = i;
					present = 1;
				end
			e.hit = present;
			if (w.command == CMD_GET) begin
				if (present) begin
					make_newest(idx);
					e.read_value = stored_val[idx];
				end else begin
					e.read_value = MISS_VALUE;
				end
			end else begin
				if (present) begin
					stored_val[idx] = w.value;
					make_newest(idx);
				end else begin
					insert_key(w.key, w.value);
				end
				e.read_value = PUT_VALUE;
			end
			owed_q.insert(owed_q.size(), e);
		endfunction

		// Compares a result word with the oldest owed result.
		function void check(rsp_t got);
			rsp_t e;
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected result word, got hit %0b value %0d",
					$time, got.hit, got.read_value);
				errors++;
				return;
			end
			e = owed_q[0];
			owed_q.delete(0);
			if (got.hit !== e.hit) begin
				$display("%0t: hit mismatch, expected %0b, got %0b", $time, e.hit, got.hit);
				errors++;
			end
			if (got.read_value !== e.read_value) begin
				$display("%0t: read_value mismatch, expected %0d, got %0d",
					$time, e.read_value, got.read_value);
				errors++;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	req_t             request;
	logic             done;
	rsp_t             result;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	cache_scoreboard sb;
	bit              took_word;
	bit              cfg_took;

	lru_key_value_cache_core #(
		.ENTRIES(ENTRIES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Free-running 100 MHz clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Samples both handshakes and the result strobe at the rising edge.
	always @(posedge clk) begin
		took_word = arst_n && start && !busy;
		cfg_took  = arst_n && cfg_valid && cfg_ready;
		if (took_word) sb.note(request);
		if (cfg_took) sb.set_capacity(cfg_data);
		if (arst_n && done) sb.check(result);
	end

	// Most gaps are short, a few are long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one request word after an optional gap and waits until it is taken.
	task automatic send_word(req_t w, int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		request = w;
		do @(negedge clk); while (!took_word);
	endtask

	task automatic op(cmd_t c, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
		req_t w;
		w.command = c;
		w.key = k;
		w.value = v;
		send_word(w, 0);
	endtask

	// Holds the sender off until every owed result has come back.
	task automatic wait_drained();
		start = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// Writes the capacity register while the cache is idle.
	task automatic write_capacity(logic [CAP_W-1:0] c);
		wait_drained();
		repeat (3) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = c;
		do @(negedge clk); while (!cfg_took);
		cfg_valid = 1'b0;
	endtask

	// Random traffic over a small key pool so that hits, updates and evictions are common.
	task automatic run_phase(int count);
		logic [DATA_W-1:0] pool[$];
		int                pool_size;
		bit                bursty;
		req_t              w;
		int                r;
		pool_size = sb.usable_capacity() + $urandom_range(1, 6);
		for (int i = 0; i < pool_size; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0) pool.insert(pool.size(), 32'h8000_0000);
			else if (r == 1) pool.insert(pool.size(), 32'h7FFF_FFFF);
			else pool.insert(pool.size(), $urandom);
		end
		bursty = ($urandom_range(0, 2) == 0);
		for (int n = 0; n < count; n++) begin
			w.command = ($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET;
			if ($urandom_range(0, 99) < 85) w.key = pool[$urandom_range(0, pool_size - 1)];
			else w.key = $urandom;
			w.value = $urandom;
			if ($urandom_range(0, 39) == 0) wait_drained();
			send_word(w, bursty ? 0 : pick_gap());
		end
	endtask

	// Limit on the whole run.
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int caps[8];
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		took_word = 0;
		cfg_took = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty store, extreme keys and values, update of a stored key.
		op(CMD_GET, 32'h0000_0000, 32'h0000_0000);
		op(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		op(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		op(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
		op(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		op(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		op(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		op(CMD_GET, 32'h0000_0000, 32'h5555_5555);
		op(CMD_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
		op(CMD_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
		op(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		op(CMD_GET, 32'h0000_0001, 32'h0000_0000);

		// Fill the store and push past it so the oldest slot is reused.
		for (int i = 0; i < 13; i++)
			op(CMD_PUT, 32'h0000_0100 + i, $urandom);

		// Lower the capacity while full; only a new key trims the store.
		write_capacity(5'd4);
		op(CMD_GET, 32'h0000_010C, 32'h0000_0000);
		op(CMD_PUT, 32'h0000_010B, 32'hCAFE_0001);
		op(CMD_PUT, 32'h0000_0200, 32'hCAFE_0002);
		op(CMD_GET, 32'h0000_0100, 32'h0000_0000);

		// Capacity zero keeps a single entry.
		write_capacity(5'd0);
		op(CMD_PUT, 32'h0000_0300, 32'h0000_0003);
		op(CMD_PUT, 32'h0000_0301, 32'h0000_0004);
		op(CMD_GET, 32'h0000_0300, 32'h0000_0000);
		op(CMD_GET, 32'h0000_0301, 32'h0000_0000);

		// Random phases across the capacity range, including the saturating top.
		caps[0] = 31;
		caps[1] = 1;
		caps[2] = 16;
		caps[3] = 0;
		caps[4] = 5;
		caps[5] = 17;
		caps[6] = 12;
		caps[7] = $urandom_range(2, 15);
		for (int p = 0; p < 8; p++) begin
			write_capacity(caps[p][CAP_W-1:0]);
			run_phase(75);
		end

		// Let the last results arrive, then allow for any stray words.
		wait_drained();
		repeat (5) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/lrukv_pkg.sv
design/lrukv_store.sv
design/lru_key_value_cache_core.sv
bench/lru_key_value_cache_core_tb.sv
